/* hw/rtl/pcc_pkg.sv */
package pcc_pkg;

    // Coordinate and arithmetic widths. Edge differences are one bit wider than a
    // coordinate, products twice that, and the cross product one bit more, so
    // nothing wraps.
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;

    // Corners closed per item: the running corner and the two wrap-around corners.
    localparam int NUM_TURNS   = 3;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [CROSS_W-1:0]     cross_t;

    typedef struct packed {
        diff_t dx;
        diff_t dy;
    } vec_t;

    // One job for the back: four consecutive edge vectors and which of the three
    // corners between them are real turns. Corner 0 lies between ea and eb,
    // corner 1 between eb and ec, corner 2 between ec and ed.
    typedef struct packed {
        vec_t                 ea;
        vec_t                 eb;
        vec_t                 ec;
        vec_t                 ed;
        logic [NUM_TURNS-1:0] turn_en;
        logic                 last;
    } job_t;

endpackage

/* hw/rtl/pcc_vertex_if.sv */
interface pcc_vertex_if import pcc_pkg::*; ();

    logic   valid;
    logic   ready;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;

    modport source (
        output valid,
        output vertex_x,
        output vertex_y,
        output last_vertex,
        input  ready
    );

    modport sink (
        input  valid,
        input  vertex_x,
        input  vertex_y,
        input  last_vertex,
        output ready
    );

endinterface

/* hw/rtl/pcc_result_if.sv */
interface pcc_result_if import pcc_pkg::*; ();

    logic valid;
    logic ready;
    logic convex;

    modport source (
        output valid,
        output convex,
        input  ready
    );

    modport sink (
        input  valid,
        input  convex,
        output ready
    );

endinterface

/* hw/rtl/polygon_convexity_check_top.sv */
// The last job passes a queue entry, back stages s1 and s2, then the result register.
// Throughput: one vertex per cycle while no result is held, set by the three
// multiplier pairs in the back, each corner of a closing vertex having its own pair.
// A result that is not taken holds the back; the two-entry queue keeps the front
// accepting for two more vertices. Reset clears the counts, queue and sign tracking;
// stored vertex coordinates are not reset and are written before they are read.
module polygon_convexity_check_top import pcc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    pcc_vertex_if.sink   vertex,
    pcc_result_if.source result
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    pcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex     (vertex),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    pcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    pcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .result    (result)
    );

    // A held result must hold the queue as well.
    a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !pop_ready)
        else $error("queue popped while a result was held");

    // The front refuses a vertex only when the queue has work waiting.
    a_refuse_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !vertex.ready |-> pop_valid)
        else $error("vertex refused with an empty queue");

    // Wrap-around corners only travel with the last vertex and its running corner.
    a_wrap_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && (pop_job.turn_en[1] || pop_job.turn_en[2]) |->
            pop_job.last && pop_job.turn_en[0])
        else $error("wrap-around corner on a job that is not last");

endmodule

/* hw/rtl/pcc_front.sv */
module pcc_front import pcc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    pcc_vertex_if.sink   vertex,
    output logic         push_valid,
    input  logic         push_ready,
    output job_t         push_job
);

    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_TWO
    } seen_t;

    seen_t  seen_reg;
    seen_t  seen_next;
    coord_t first_x_reg;
    coord_t first_y_reg;
    coord_t second_x_reg;
    coord_t second_y_reg;
    coord_t older_x_reg;
    coord_t older_y_reg;
    coord_t newer_x_reg;
    coord_t newer_y_reg;
    logic   accept;

    // Every accepted vertex becomes one job, so the front stalls only on a full queue.
    assign accept       = vertex.valid && push_ready;
    assign vertex.ready = push_ready;
    assign push_valid   = vertex.valid;

    // Edge vectors around the new vertex, formed at full precision.
    always_comb
    begin
        push_job.ea.dx = DIFF_W'(newer_x_reg) - DIFF_W'(older_x_reg);
        push_job.ea.dy = DIFF_W'(newer_y_reg) - DIFF_W'(older_y_reg);
        push_job.eb.dx = DIFF_W'(vertex.vertex_x) - DIFF_W'(newer_x_reg);
        push_job.eb.dy = DIFF_W'(vertex.vertex_y) - DIFF_W'(newer_y_reg);
        push_job.ec.dx = DIFF_W'(first_x_reg) - DIFF_W'(vertex.vertex_x);
        push_job.ec.dy = DIFF_W'(first_y_reg) - DIFF_W'(vertex.vertex_y);
        push_job.ed.dx = DIFF_W'(second_x_reg) - DIFF_W'(first_x_reg);
        push_job.ed.dy = DIFF_W'(second_y_reg) - DIFF_W'(first_y_reg);
        push_job.last  = vertex.last_vertex;
        if (seen_reg == SEEN_TWO)
        begin
            push_job.turn_en = {vertex.last_vertex, vertex.last_vertex, 1'b1};
        end
        else
        begin
            push_job.turn_en = '0;
        end
    end

    // Vertex count, saturating at two and rearmed by the last vertex.
    always_comb
    begin
        seen_next = seen_reg;
        if (accept)
        begin
            if (vertex.last_vertex)
            begin
                seen_next = SEEN_NONE;
            end
            else
            begin
                unique case (seen_reg)
                    SEEN_NONE: seen_next = SEEN_ONE;
                    SEEN_ONE:  seen_next = SEEN_TWO;
                    SEEN_TWO:  seen_next = SEEN_TWO;
                    default:   seen_next = SEEN_NONE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= SEEN_NONE;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    // Stored vertices are read only once the count shows they were written.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            unique case (seen_reg)
                SEEN_NONE:
                begin
                    first_x_reg <= vertex.vertex_x;
                    first_y_reg <= vertex.vertex_y;
                end
                SEEN_ONE:
                begin
                    second_x_reg <= vertex.vertex_x;
                    second_y_reg <= vertex.vertex_y;
                    older_x_reg  <= newer_x_reg;
                    older_y_reg  <= newer_y_reg;
                end
                default:
                begin
                    older_x_reg <= newer_x_reg;
                    older_y_reg <= newer_y_reg;
                end
            endcase
            newer_x_reg <= vertex.vertex_x;
            newer_y_reg <= vertex.vertex_y;
        end
    end

endmodule

/* hw/rtl/pcc_queue.sv */
module pcc_queue import pcc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1))
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (do_pop)
            begin
                if (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1))
                begin
                    rd_ptr_reg <= '0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hw/rtl/pcc_back.sv */
module pcc_back import pcc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  job_t         pop_job,
    pcc_result_if.source result
);

    vec_t                 u_vec [NUM_TURNS];
    vec_t                 v_vec [NUM_TURNS];
    prod_t                prod_a [NUM_TURNS];
    prod_t                prod_b [NUM_TURNS];
    cross_t               cross_val [NUM_TURNS];
    logic                 adv;

    logic                 s1_valid_reg;
    prod_t                s1_pa_reg [NUM_TURNS];
    prod_t                s1_pb_reg [NUM_TURNS];
    logic [NUM_TURNS-1:0] s1_en_reg;
    logic                 s1_last_reg;

    logic [NUM_TURNS-1:0] s2_nz_next;
    logic [NUM_TURNS-1:0] s2_pos_next;
    logic                 s2_valid_reg;
    logic [NUM_TURNS-1:0] s2_nz_reg;
    logic [NUM_TURNS-1:0] s2_pos_reg;
    logic                 s2_last_reg;

    logic                 known_reg;
    logic                 known_next;
    logic                 ref_pos_reg;
    logic                 ref_pos_next;
    logic                 conflict_reg;
    logic                 conflict_next;
    logic                 out_valid_reg;
    logic                 convex_reg;

    // The whole back holds while a finished result waits to be taken.
    assign adv       = !(out_valid_reg && !result.ready);
    assign pop_ready = adv;

    assign u_vec[0] = pop_job.ea;
    assign v_vec[0] = pop_job.eb;
    assign u_vec[1] = pop_job.eb;
    assign v_vec[1] = pop_job.ec;
    assign u_vec[2] = pop_job.ec;
    assign v_vec[2] = pop_job.ed;

    // Stage 1: the two products of each cross product, one multiplier pair per corner.
    for (genvar i = 0; i < NUM_TURNS; i++)
    begin : g_mul
        diff_t ux;
        diff_t uy;
        diff_t vx;
        diff_t vy;
        assign ux        = u_vec[i].dx;
        assign uy        = u_vec[i].dy;
        assign vx        = v_vec[i].dx;
        assign vy        = v_vec[i].dy;
        assign prod_a[i] = ux * vy;
        assign prod_b[i] = uy * vx;
    end

    // Stage 2: the cross products, of which only the sign and whether it is nonzero are kept.
    for (genvar i = 0; i < NUM_TURNS; i++)
    begin : g_sign
        assign cross_val[i]   = CROSS_W'(s1_pa_reg[i]) - CROSS_W'(s1_pb_reg[i]);
        assign s2_nz_next[i]  = s1_en_reg[i] && (cross_val[i] != '0);
        assign s2_pos_next[i] = !cross_val[i][CROSS_W-1];
    end

    // Stage 3: the corners of one item are applied in polygon order. The first
    // nonzero turn sets the reference sign and any opposite one marks a conflict.
    always_comb
    begin
        known_next    = known_reg;
        ref_pos_next  = ref_pos_reg;
        conflict_next = conflict_reg;
        for (int i = 0; i < NUM_TURNS; i++)
        begin
            if (s2_nz_reg[i])
            begin
                if (!known_next)
                begin
                    known_next   = 1'b1;
                    ref_pos_next = s2_pos_reg[i];
                end
                else if (s2_pos_reg[i] != ref_pos_next)
                begin
                    conflict_next = 1'b1;
                end
            end
        end
    end

    // Control and sign tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            known_reg     <= 1'b0;
            ref_pos_reg   <= 1'b0;
            conflict_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_last_reg;
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    known_reg    <= 1'b0;
                    ref_pos_reg  <= 1'b0;
                    conflict_reg <= 1'b0;
                end
                else
                begin
                    known_reg    <= known_next;
                    ref_pos_reg  <= ref_pos_next;
                    conflict_reg <= conflict_next;
                end
            end
        end
    end

    // Pipeline payload and the result register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pa_reg   <= prod_a;
            s1_pb_reg   <= prod_b;
            s1_en_reg   <= pop_job.turn_en;
            s1_last_reg <= pop_job.last;
            s2_nz_reg   <= s2_nz_next;
            s2_pos_reg  <= s2_pos_next;
            s2_last_reg <= s1_last_reg;
            if (s2_valid_reg && s2_last_reg)
            begin
                convex_reg <= !conflict_next;
            end
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.convex = convex_reg;

endmodule
